// File: hdl/escape_sequence_decoder_macros.svh
// assertion macros for the escape sequence decoder
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define ESD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/esd_pkg.sv
`default_nettype none
package esd_pkg;

  localparam int CHAR_W = 8;
  localparam int VAL_W  = 31;

  // parse mode codes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_ZERO  = 2'd2;
  localparam logic [1:0] MODE_NUM   = 2'd3;

  // number base codes
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // configuration register index
  localparam logic REG_LITERAL_BACKSLASH = 1'b0;

  localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;
  localparam logic [VAL_W-1:0]  VALUE_MAX = {VAL_W{1'b1}};

  // result buffer depth
  localparam int BUF_DEPTH = 4;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              is_last;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/esd_ifs.sv
`default_nettype none
// input character channel
interface esd_in_if;
  logic                        valid;
  logic                        ready;
  logic [esd_pkg::CHAR_W-1:0]  in_char;
  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

// decoded character channel
interface esd_out_if;
  logic                        valid;
  logic                        ready;
  logic [esd_pkg::CHAR_W-1:0]  out_char;
  logic                        is_last;
  modport source (output valid, output out_char, output is_last, input ready);
  modport sink (input valid, input out_char, input is_last, output ready);
endinterface
`default_nettype wire

// File: hdl/escape_sequence_decoder.sv
`default_nettype none
// channel  | dir | handshake     | payload
// -------- | --- | ------------- | -----------------------
// in_ch    | in  | valid / ready | in_char[7:0]
// out_ch   | out | valid / ready | out_char[7:0], is_last
// apb cfg  | in  | psel/penable  | paddr[2:0], pwdata[31:0]
//
// one character request is taken per cycle; its zero, one or two results are
// decoded in the same cycle and written into a four-entry result buffer.
// results leave the buffer one per cycle while out_ch.ready is high, and
// in_ch.ready drops while more than two results wait in the buffer.
// rst_n (synchronous) clears the parse state, literal_backslash and the buffer.
`include "escape_sequence_decoder_macros.svh"

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  esd_in_if.sink           in_ch,
  esd_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  logic               lit_r;
  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         base_r, base_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;

  result_t            buf_r [BUF_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               in_acc, out_acc;
  logic [CHAR_W-1:0]  c;
  logic [1:0]         n_res;
  result_t            res0, res1;

  // named escape lookup
  function automatic logic [CHAR_W:0] named_esc(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W:0] r;
    r = '0;
    case (ch)
      8'h65:     r = {1'b1, 8'd27};
      8'h72:     r = {1'b1, 8'd13};
      8'h66:     r = {1'b1, 8'd12};
      8'h76:     r = {1'b1, 8'd11};
      8'h6E:     r = {1'b1, 8'd10};
      8'h74:     r = {1'b1, 8'd9};
      8'h62:     r = {1'b1, 8'd8};
      BACKSLASH: r = {1'b1, BACKSLASH};
      default:   r = '0;
    endcase
    return r;
  endfunction

  // apb port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LITERAL_BACKSLASH) ? {31'b0, lit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_LITERAL_BACKSLASH) begin
      lit_r <= pwdata[0];
    end
  end

  // handshakes
  assign in_ch.ready = (cnt_r <= CNT_W'(BUF_DEPTH - 2));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign c           = in_ch.in_char;

  // digit classification
  logic             is_dec, is_lo_hex, is_up_hex, is_digit;
  logic [3:0]       dig;
  logic [VAL_W+4:0] prod, acc_sum;
  logic [VAL_W-1:0] val_sat;

  always_comb begin
    is_dec    = (c inside {[8'h30:8'h39]});
    is_lo_hex = (c inside {[8'h61:8'h66]});
    is_up_hex = (c inside {[8'h41:8'h46]});
    dig       = is_dec ? c[3:0] : c[3:0] + 4'd9;
    case (base_r)
      BASE_OCT: is_digit = (c inside {[8'h30:8'h37]});
      BASE_DEC: is_digit = is_dec;
      default:  is_digit = is_dec || is_lo_hex || is_up_hex;
    endcase
  end

  // value times radix plus digit, saturating
  always_comb begin
    case (base_r)
      BASE_OCT: prod = {5'b0, val_r} << 3;
      BASE_DEC: prod = ({5'b0, val_r} << 3) + ({5'b0, val_r} << 1);
      default:  prod = {5'b0, val_r} << 4;
    endcase
    acc_sum = prod + {{(VAL_W+1){1'b0}}, dig};
    val_sat = (acc_sum > {5'b0, VALUE_MAX}) ? VALUE_MAX : acc_sum[VAL_W-1:0];
  end

  // plain text handling of the current character
  logic    plain_esc;
  result_t plain_res;
  logic [CHAR_W:0] named;

  assign plain_esc          = (c == BACKSLASH) && !lit_r;
  assign plain_res.out_char = c;
  assign plain_res.is_last  = (c == '0);
  assign named              = named_esc(c);

  // decode one character
  always_comb begin
    mode_nxt = MODE_PLAIN;
    base_nxt = base_r;
    val_nxt  = val_r;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;
    case (mode_r)
      MODE_ESC: begin
        if (c == '0) begin
          res0  = '{out_char: BACKSLASH, is_last: 1'b0};
          res1  = '{out_char: '0, is_last: 1'b1};
          n_res = 2'd2;
        end else if (c == 8'h30) begin
          mode_nxt = MODE_ZERO;
        end else if (c == 8'h78) begin
          mode_nxt = MODE_NUM;
          base_nxt = BASE_HEX;
          val_nxt  = '0;
        end else if (named[CHAR_W]) begin
          res0  = '{out_char: named[CHAR_W-1:0], is_last: 1'b0};
          n_res = 2'd1;
        end else if (c inside {[8'h31:8'h39]}) begin
          mode_nxt = MODE_NUM;
          base_nxt = BASE_DEC;
          val_nxt  = {{(VAL_W-4){1'b0}}, c[3:0]};
        end else begin
          res0  = '{out_char: BACKSLASH, is_last: 1'b0};
          res1  = '{out_char: c, is_last: 1'b0};
          n_res = 2'd2;
        end
      end
      MODE_ZERO: begin
        if (c == 8'h78 || c == 8'h58) begin
          mode_nxt = MODE_NUM;
          base_nxt = BASE_HEX;
          val_nxt  = '0;
        end else if (c inside {[8'h30:8'h37]}) begin
          mode_nxt = MODE_NUM;
          base_nxt = BASE_OCT;
          val_nxt  = {{(VAL_W-4){1'b0}}, c[3:0]};
        end else begin
          res0 = '{out_char: '0, is_last: 1'b0};
          if (plain_esc) begin
            mode_nxt = MODE_ESC;
            n_res    = 2'd1;
          end else begin
            res1  = plain_res;
            n_res = 2'd2;
          end
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          mode_nxt = MODE_NUM;
          val_nxt  = val_sat;
        end else begin
          res0     = '{out_char: val_r[CHAR_W-1:0], is_last: 1'b0};
          val_nxt  = '0;
          base_nxt = BASE_OCT;
          if (plain_esc) begin
            mode_nxt = MODE_ESC;
            n_res    = 2'd1;
          end else begin
            res1  = plain_res;
            n_res = 2'd2;
          end
        end
      end
      default: begin
        if (plain_esc) begin
          mode_nxt = MODE_ESC;
        end else begin
          res0  = plain_res;
          n_res = 2'd1;
        end
      end
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      base_r <= BASE_OCT;
      val_r  <= '0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      base_r <= base_nxt;
      val_r  <= val_nxt;
    end
  end

  // result buffer
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + CNT_W'(n_res);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      buf_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      buf_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_char = buf_r[rd_ptr_r].out_char;
  assign out_ch.is_last  = buf_r[rd_ptr_r].is_last;

  // checks
  `ESD_ASSERT_NOW(a_buf_bound, 1'b1, cnt_r <= CNT_W'(BUF_DEPTH), "result buffer overflow")
  `ESD_ASSERT_NOW(a_room_on_accept, in_acc, cnt_r <= CNT_W'(BUF_DEPTH - 2), "no room for request")
  `ESD_ASSERT_NEXT(a_nul_ends, in_acc && c == '0, mode_r == MODE_PLAIN, "nul left escape open")
  `ESD_ASSERT_NEXT(a_drain, out_acc && !in_acc, cnt_r == $past(cnt_r) - CNT_W'(1), "bad drain count")

endmodule
`default_nettype wire
